FILE: hdl/mpct_pkg.sv
`timescale 1ns / 1ps

package mpct_pkg;

   // configuration register width and indexes
   localparam int CSR_W      = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int COORD_BITS_DEFAULT = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [CSR_W-1:0] SCREEN_WIDTH_RESET  = CSR_W'(320);
   localparam logic [CSR_W-1:0] SCREEN_HEIGHT_RESET = CSR_W'(240);
   localparam logic [CSR_W-1:0] EDGE_MARGIN         = CSR_W'(5);

   // header bit positions
   localparam int HDR_X_SIGN = 4;
   localparam int HDR_Y_SIGN = 5;

   // key flag bit positions
   localparam int FLAG_DOWN  = 0;
   localparam int FLAG_UP    = 1;
   localparam int FLAG_DHOLD = 2;
   localparam int FLAG_UHOLD = 3;

   localparam logic [3:0] KEY_STATE_RESET = 4'b1000;

   typedef enum logic [1:0] {
      KEY_LEFT   = 2'd0,
      KEY_RIGHT  = 2'd1,
      KEY_MIDDLE = 2'd2
   } key_kind_type;

   typedef enum logic [1:0] {
      PAIR_UP_HELD   = 2'b00,
      PAIR_PRESSED   = 2'b01,
      PAIR_RELEASED  = 2'b10,
      PAIR_DOWN_HELD = 2'b11
   } key_pair_type;

   // flag update from previous and current button bit, per key rules
   function automatic logic [3:0] key_update(input logic [3:0] st, input logic p,
                                             input logic c, input key_kind_type kind);
      logic [3:0] s;
      s = st;
      case (key_pair_type'({p, c}))
         PAIR_PRESSED: begin
            s[FLAG_DOWN]  = 1'b1;
            s[FLAG_UHOLD] = 1'b0;
            if (kind == KEY_RIGHT) s[FLAG_DHOLD] = 1'b0;
         end
         PAIR_RELEASED: begin
            s[FLAG_UP]    = 1'b1;
            s[FLAG_DOWN]  = 1'b0;
            s[FLAG_DHOLD] = 1'b0;
         end
         PAIR_DOWN_HELD: begin
            s[FLAG_DHOLD] = 1'b1;
            s[FLAG_DOWN]  = 1'b0;
         end
         default: begin
            if (kind == KEY_LEFT) begin
               s[FLAG_UP]    = st[FLAG_DOWN] | st[FLAG_DHOLD];
               s[FLAG_DHOLD] = 1'b0;
            end else begin
               s[FLAG_UP] = 1'b0;
               if (kind == KEY_RIGHT) s[FLAG_DHOLD] = 1'b0;
            end
            s[FLAG_UHOLD] = 1'b1;
            s[FLAG_DOWN]  = 1'b0;
         end
      endcase
      return s;
   endfunction

endpackage

FILE: hdl/mouse_packet_cursor_tracker.sv
`timescale 1ns / 1ps

// a beat from req_ passes the input register, then the result register, to rsp_
// throughput: one beat per cycle while rsp_ready is high; input register and result
// register each take a beat while the next one is held, so req_ready only drops when
// both are full and stalled; sustained idle ticks are consumed without a result
// reset (synchronous, active high) clears cursor, wheel, buttons and handshake state,
// key flags to up-hold, screen size to 320 by 240
module mouse_packet_cursor_tracker
   import mpct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_W-1:0]             csr_data,
   // packet input
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_idle_tick,
   input  logic [7:0]                   req_header_byte,
   input  logic [7:0]                   req_x_move,
   input  logic [7:0]                   req_y_move,
   input  logic [7:0]                   req_wheel_move,
   // result output
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [3:0]                   rsp_left_flags,
   output logic [3:0]                   rsp_right_flags,
   output logic [3:0]                   rsp_middle_flags,
   output logic                         rsp_keys_idle,
   output logic [COORD_BITS-1:0]        rsp_cursor_x,
   output logic [COORD_BITS-1:0]        rsp_cursor_y,
   output logic signed [COORD_BITS:0]   rsp_delta_x,
   output logic signed [COORD_BITS:0]   rsp_delta_y,
   output logic signed [7:0]            rsp_delta_wheel,
   output logic signed [15:0]           rsp_wheel_pos
);

   localparam int LIM_W = (COORD_BITS > CSR_W) ? COORD_BITS : CSR_W;
   localparam int SUM_W = COORD_BITS + 2;

   // clamp limit from a screen size: size minus margin, floored at zero, capped
   function automatic logic [COORD_BITS-1:0] edge_limit(input logic [CSR_W-1:0] size);
      logic [LIM_W-1:0] lim;
      logic [LIM_W-1:0] cap;
      lim = (size < EDGE_MARGIN) ? '0 : LIM_W'(size - EDGE_MARGIN);
      cap = LIM_W'({COORD_BITS{1'b1}});
      if (lim > cap) lim = cap;
      return lim[COORD_BITS-1:0];
   endfunction

   // new position from old position and signed move
   function automatic logic [COORD_BITS-1:0] clamp_axis(input logic [COORD_BITS-1:0] pos,
                                                         input logic signed [9:0] mv,
                                                         input logic [COORD_BITS-1:0] lim);
      logic signed [SUM_W-1:0] v;
      v = $signed({2'b00, pos}) + SUM_W'(mv);
      if (v < 0) return '0;
      if (v > $signed({2'b00, lim})) return lim;
      return v[COORD_BITS-1:0];
   endfunction

   // configuration: clamp limits worked out at write time
   logic [COORD_BITS-1:0] limit_x_ff;
   logic [COORD_BITS-1:0] limit_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_x_ff <= edge_limit(SCREEN_WIDTH_RESET);
         limit_y_ff <= edge_limit(SCREEN_HEIGHT_RESET);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SCREEN_WIDTH:  limit_x_ff <= edge_limit(csr_data);
            CSR_SCREEN_HEIGHT: limit_y_ff <= edge_limit(csr_data);
            default: ;
         endcase
      end
   end

   // input register
   logic       s1_valid_ff;
   logic       s1_idle_ff;
   logic [7:0] s1_header_ff;
   logic [7:0] s1_x_ff;
   logic [7:0] s1_y_ff;
   logic [7:0] s1_wheel_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_idle_ff   <= req_idle_tick;
         s1_header_ff <= req_header_byte;
         s1_x_ff      <= req_x_move;
         s1_y_ff      <= req_y_move;
         s1_wheel_ff  <= req_wheel_move;
      end
   end

   // tracker state
   logic [2:0]            prev_buttons_ff;
   logic                  idle_sustained_ff;
   logic [3:0]            left_key_state_ff;
   logic [3:0]            right_key_state_ff;
   logic [3:0]            middle_key_state_ff;
   logic [COORD_BITS-1:0] pos_x_ff;
   logic [COORD_BITS-1:0] pos_y_ff;
   logic [15:0]           wheel_acc_ff;

   // packet decode: idle replay uses last buttons and no motion
   logic                  drop;
   logic                  emit;
   logic [7:0]            hdr;
   logic [7:0]            xm;
   logic [7:0]            ym;
   logic [7:0]            wm;
   logic [2:0]            cur;
   logic signed [9:0]     dx;
   logic signed [9:0]     dy;
   logic [3:0]            left_in;
   logic [3:0]            right_in;
   logic [3:0]            middle_in;
   logic [COORD_BITS-1:0] pos_x_in;
   logic [COORD_BITS-1:0] pos_y_in;
   logic [15:0]           wheel_acc_in;

   assign drop = s1_idle_ff && idle_sustained_ff;
   assign emit = advance && !drop;

   always_comb begin
      if (s1_idle_ff) begin
         hdr = {5'b0, prev_buttons_ff};
         xm  = '0;
         ym  = '0;
         wm  = '0;
      end else begin
         hdr = s1_header_ff;
         xm  = s1_x_ff;
         ym  = s1_y_ff;
         wm  = s1_wheel_ff;
      end
      cur = hdr[2:0];
      dx  = $signed({{2{hdr[HDR_X_SIGN]}}, xm});
      dy  = -$signed({{2{hdr[HDR_Y_SIGN]}}, ym});
      left_in   = key_update(left_key_state_ff,   prev_buttons_ff[0], cur[0], KEY_LEFT);
      right_in  = key_update(right_key_state_ff,  prev_buttons_ff[1], cur[1], KEY_RIGHT);
      middle_in = key_update(middle_key_state_ff, prev_buttons_ff[2], cur[2], KEY_MIDDLE);
      pos_x_in  = clamp_axis(pos_x_ff, dx, limit_x_ff);
      pos_y_in  = clamp_axis(pos_y_ff, dy, limit_y_ff);
      wheel_acc_in = wheel_acc_ff + {{8{wm[7]}}, wm};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_buttons_ff     <= '0;
         idle_sustained_ff   <= 1'b0;
         left_key_state_ff   <= KEY_STATE_RESET;
         right_key_state_ff  <= KEY_STATE_RESET;
         middle_key_state_ff <= KEY_STATE_RESET;
         pos_x_ff            <= '0;
         pos_y_ff            <= '0;
         wheel_acc_ff        <= '0;
      end else if (emit) begin
         prev_buttons_ff     <= cur;
         idle_sustained_ff   <= s1_idle_ff;
         left_key_state_ff   <= left_in;
         right_key_state_ff  <= right_in;
         middle_key_state_ff <= middle_in;
         pos_x_ff            <= pos_x_in;
         pos_y_ff            <= pos_y_in;
         wheel_acc_ff        <= wheel_acc_in;
      end
   end

   // result register
   logic [3:0]                 left_flags_ff;
   logic [3:0]                 right_flags_ff;
   logic [3:0]                 middle_flags_ff;
   logic [COORD_BITS-1:0]      cursor_x_ff;
   logic [COORD_BITS-1:0]      cursor_y_ff;
   logic signed [COORD_BITS:0] delta_x_ff;
   logic signed [COORD_BITS:0] delta_y_ff;
   logic signed [7:0]          delta_wheel_ff;
   logic [15:0]                wheel_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         left_flags_ff   <= left_in;
         right_flags_ff  <= right_in;
         middle_flags_ff <= middle_in;
         cursor_x_ff     <= pos_x_in;
         cursor_y_ff     <= pos_y_in;
         delta_x_ff      <= $signed({1'b0, pos_x_in}) - $signed({1'b0, pos_x_ff});
         delta_y_ff      <= $signed({1'b0, pos_y_in}) - $signed({1'b0, pos_y_ff});
         delta_wheel_ff  <= $signed(wm);
         wheel_pos_ff    <= wheel_acc_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_flags   = left_flags_ff;
   assign rsp_right_flags  = right_flags_ff;
   assign rsp_middle_flags = middle_flags_ff;
   assign rsp_keys_idle    = left_flags_ff[FLAG_UHOLD] & right_flags_ff[FLAG_UHOLD]
                             & middle_flags_ff[FLAG_UHOLD];
   assign rsp_cursor_x     = cursor_x_ff;
   assign rsp_cursor_y     = cursor_y_ff;
   assign rsp_delta_x      = delta_x_ff;
   assign rsp_delta_y      = delta_y_ff;
   assign rsp_delta_wheel  = delta_wheel_ff;
   assign rsp_wheel_pos    = $signed(wheel_pos_ff);

   // checks

   // a waiting beat in the input register is not overwritten
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_header_ff))
      else $error("input register lost a waiting beat");

   // a sustained idle tick never raises a result
   a_idle_drop: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && drop && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("sustained idle tick produced a result");

   // idle replay gives a result with no wheel movement
   a_idle_replay: assert property (@(posedge clock) disable iff (reset)
      advance && s1_idle_ff && !idle_sustained_ff |=> rsp_valid_ff && delta_wheel_ff == 0)
      else $error("idle replay result missing or moved the wheel");

   // results stay inside the clamp window
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> cursor_x_ff <= limit_x_ff && cursor_y_ff <= limit_y_ff)
      else $error("cursor beyond the screen limit");

endmodule
